// ----- rtl/itoa_pkg.sv -----
package itoa_pkg;

  // ASCII codes and radix limits
  localparam logic [6:0] CH_ZERO  = 7'd48;
  localparam logic [6:0] CH_A     = 7'd65;
  localparam logic [6:0] CH_MINUS = 7'd45;
  localparam logic [5:0] MIN_RADIX  = 6'd2;
  localparam logic [5:0] MAX_RADIX  = 6'd36;
  localparam logic [5:0] SIGN_RADIX = 6'd10;
  localparam logic [5:0] LAST_DECIMAL = 6'd9;

  // Program counter and step addresses of the control store
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] STEP_ACCEPT = 3'd0;
  localparam logic [PC_W-1:0] STEP_DIV    = 3'd1;
  localparam logic [PC_W-1:0] STEP_DIGIT  = 3'd2;
  localparam logic [PC_W-1:0] STEP_SIGN   = 3'd3;
  localparam logic [PC_W-1:0] STEP_MINUS  = 3'd4;
  localparam logic [PC_W-1:0] STEP_READ   = 3'd5;
  localparam logic [PC_W-1:0] STEP_EMIT   = 3'd6;
  localparam logic [PC_W-1:0] STEP_END    = 3'd7;

  typedef enum logic [1:0] {
    WAIT_NONE = 2'd0,
    WAIT_IN   = 2'd1,
    WAIT_OUT  = 2'd2
  } wait_t;

  typedef enum logic [2:0] {
    J_NEXT       = 3'd0,
    J_ALWAYS     = 3'd1,
    J_CHUNK_MORE = 3'd2,
    J_QUOT_NZ    = 3'd3,
    J_NOT_NEG    = 3'd4,
    J_COUNT_MORE = 3'd5
  } jump_t;

  typedef struct packed {
    wait_t           wt;
    jump_t           jc;
    logic [PC_W-1:0] target;
    logic            load;
    logic            div_step;
    logic            store;
    logic            set_len;
    logic            rd;
    logic            emit_minus;
    logic            emit_digit;
  } uword_t;

  typedef struct packed {
    logic load;
    logic step;
    logic clear;
  } div_ctrl_t;

  typedef struct packed {
    logic [5:0] rem;
    logic       quot_nz;
    logic       chunk_more;
  } div_stat_t;

  // Control store: one word per step
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    w.wt = WAIT_NONE;
    w.jc = J_NEXT;
    case (pc)
      STEP_ACCEPT: begin
        w.wt = WAIT_IN;
        w.load = 1'b1;
      end
      STEP_DIV: begin
        w.div_step = 1'b1;
        w.jc = J_CHUNK_MORE;
        w.target = STEP_DIV;
      end
      STEP_DIGIT: begin
        w.store = 1'b1;
        w.jc = J_QUOT_NZ;
        w.target = STEP_DIV;
      end
      STEP_SIGN: begin
        w.set_len = 1'b1;
        w.jc = J_NOT_NEG;
        w.target = STEP_READ;
      end
      STEP_MINUS: begin
        w.wt = WAIT_OUT;
        w.emit_minus = 1'b1;
      end
      STEP_READ: begin
        w.rd = 1'b1;
      end
      STEP_EMIT: begin
        w.wt = WAIT_OUT;
        w.emit_digit = 1'b1;
        w.jc = J_COUNT_MORE;
        w.target = STEP_READ;
      end
      default: begin
        w.jc = J_ALWAYS;
        w.target = STEP_ACCEPT;
      end
    endcase
    return w;
  endfunction

  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [6:0] base_code;
    base_code = (d > LAST_DECIMAL) ? (CH_A - 7'd10) : CH_ZERO;
    return 7'(d) + base_code;
  endfunction

endpackage

// ----- rtl/itoa_div.sv -----
module itoa_div #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  itoa_pkg::div_ctrl_t     ctrl,
  input  logic [WORD_WIDTH-1:0]   operand,
  input  logic [5:0]              radix,
  output itoa_pkg::div_stat_t     stat
);

  localparam int CHUNKS = (WORD_WIDTH + 7) / 8;
  localparam int DIV_W  = CHUNKS * 8;
  localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  logic [DIV_W-1:0] quot;
  logic [5:0]       rem;
  logic [CH_W-1:0]  chunk;

  logic [5:0] rem_next;
  logic [7:0] qbits;

  // Eight restoring steps on the top byte; remainder stays below the radix
  always_comb begin
    logic [7:0] top;
    logic [6:0] trial;
    logic [5:0] r;
    top = quot[DIV_W-1 -: 8];
    r = rem;
    qbits = '0;
    for (int i = 7; i >= 0; i--) begin
      trial = {r, top[i]};
      if (trial >= {1'b0, radix}) begin
        r = 6'(trial - {1'b0, radix});
        qbits[i] = 1'b1;
      end else begin
        r = trial[5:0];
      end
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quot <= DIV_W'(operand);
      rem <= '0;
    end else if (ctrl.step) begin
      quot <= (quot << 8) | DIV_W'(qbits);
      rem <= rem_next;
    end else if (ctrl.clear) begin
      rem <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= '0;
    end else if (ctrl.load || ctrl.clear) begin
      chunk <= '0;
    end else if (ctrl.step) begin
      chunk <= chunk + CH_W'(1);
    end
  end

  assign stat.rem = rem;
  assign stat.quot_nz = |quot;
  assign stat.chunk_more = (chunk != CH_W'(CHUNKS - 1));

endmodule

// ----- rtl/integer_to_ascii_radix.sv -----
// Binary to ASCII conversion in radix 2..36. Each transfer on the input
// channel (value, base, mode) yields one transfer per output character, most
// significant first: '0'-'9' and 'A'-'Z', a leading '-' for a negative word in
// signed mode with radix 10, and a single '0' for zero. Every character
// carries the total length and is_last marks the final one. A radix below 2
// is taken as 2 and one above 36 as 36. Only the low WORD_WIDTH bits of value
// are used. A small control store sequences a shared divider that retires
// eight quotient bits per cycle: each digit takes one divider step for each
// of the C = ceil(WORD_WIDTH/8) bytes of the word, then a store of the
// remainder. Each emitted character takes a digit buffer read and an output
// load that waits out any output stall, and a negative word first emits its
// sign. The output register lets the next word be taken while the last
// character still waits to be accepted downstream.
module integer_to_ascii_radix #(
  parameter int WORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] value,
  input  logic [5:0]  base,
  input  logic        mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  character,
  output logic        is_last,
  output logic [5:0]  length
);

  localparam int VW      = (WORD_WIDTH > 32) ? WORD_WIDTH : 32;
  localparam int IDX_W   = $clog2(WORD_WIDTH);
  localparam int CNT_W   = $clog2(WORD_WIDTH + 1);
  localparam int LEN_W   = $clog2(WORD_WIDTH + 2);
  localparam int LEN_PAD = (LEN_W < 6) ? 6 : LEN_W;

  // Sequencer state
  logic [itoa_pkg::PC_W-1:0] pc;
  itoa_pkg::uword_t          uw;
  logic                      go;
  logic                      jump;

  // Datapath registers
  logic [5:0]       radix;
  logic             neg;
  logic [CNT_W-1:0] count;
  logic [LEN_W-1:0] len;
  logic [5:0]       rd_digit;
  logic [5:0]       digit_buffer [WORD_WIDTH];

  itoa_pkg::div_ctrl_t div_ctrl;
  itoa_pkg::div_stat_t div_stat;

  // Input word decode
  logic [VW-1:0]         value_ext;
  logic [WORD_WIDTH-1:0] word;
  logic [5:0]            radix_in;
  logic                  neg_in;
  logic [WORD_WIDTH-1:0] magnitude;
  logic                  out_free;
  logic [LEN_PAD-1:0]    len_pad;
  logic [IDX_W-1:0]      rd_idx;

  assign value_ext = VW'(value);
  assign word = value_ext[WORD_WIDTH-1:0];

  // Saturate the radix into 2..36
  always_comb begin
    if (base < itoa_pkg::MIN_RADIX) begin
      radix_in = itoa_pkg::MIN_RADIX;
    end else if (base > itoa_pkg::MAX_RADIX) begin
      radix_in = itoa_pkg::MAX_RADIX;
    end else begin
      radix_in = base;
    end
  end

  // Sign only counts in signed decimal; negate modulo 2^WORD_WIDTH, so the
  // most negative word comes out as its exact magnitude
  assign neg_in = mode && (radix_in == itoa_pkg::SIGN_RADIX) && word[WORD_WIDTH-1];
  assign magnitude = neg_in ? (~word + WORD_WIDTH'(1)) : word;

  // Fetch the control word and decide whether this step may run
  assign uw = itoa_pkg::ucode(pc);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (uw.wt)
      itoa_pkg::WAIT_NONE: go = 1'b1;
      itoa_pkg::WAIT_IN:   go = in_valid;
      itoa_pkg::WAIT_OUT:  go = out_free;
      default:             go = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.jc)
      itoa_pkg::J_NEXT:       jump = 1'b0;
      itoa_pkg::J_ALWAYS:     jump = 1'b1;
      itoa_pkg::J_CHUNK_MORE: jump = div_stat.chunk_more;
      itoa_pkg::J_QUOT_NZ:    jump = div_stat.quot_nz;
      itoa_pkg::J_NOT_NEG:    jump = !neg;
      itoa_pkg::J_COUNT_MORE: jump = (count != CNT_W'(1));
      default:                jump = 1'b0;
    endcase
  end

  assign in_stall = (uw.wt != itoa_pkg::WAIT_IN);

  // Hold on a wait, otherwise jump or advance
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= itoa_pkg::STEP_ACCEPT;
    end else if (go) begin
      pc <= jump ? uw.target : pc + itoa_pkg::PC_W'(1);
    end
  end

  // Shared divider: one quotient byte per cycle
  assign div_ctrl.load  = go && uw.load;
  assign div_ctrl.step  = go && uw.div_step;
  assign div_ctrl.clear = go && uw.store;

  itoa_div #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .ctrl(div_ctrl),
    .operand(magnitude),
    .radix(radix),
    .stat(div_stat)
  );

  // Latch the conversion controls and count digits up, then back down
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itoa_pkg::MIN_RADIX;
      neg <= 1'b0;
      count <= '0;
      len <= '0;
    end else if (go) begin
      if (uw.load) begin
        radix <= radix_in;
        neg <= neg_in;
        count <= '0;
      end
      if (uw.store) begin
        count <= count + CNT_W'(1);
      end
      if (uw.emit_digit) begin
        count <= count - CNT_W'(1);
      end
      if (uw.set_len) begin
        len <= LEN_W'(count) + LEN_W'(neg);
      end
    end
  end

  // Digit buffer: write the remainder, read back most significant first
  assign rd_idx = IDX_W'(count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (go && uw.store) begin
      digit_buffer[count[IDX_W-1:0]] <= div_stat.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (go && uw.rd) begin
      rd_digit <= digit_buffer[rd_idx];
    end
  end

  // Output register
  assign len_pad = LEN_PAD'(len);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && (uw.emit_minus || uw.emit_digit)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && uw.emit_minus) begin
      character <= itoa_pkg::CH_MINUS;
      is_last <= 1'b0;
      length <= len_pad[5:0];
    end else if (go && uw.emit_digit) begin
      character <= itoa_pkg::digit_char(rd_digit);
      is_last <= (count == CNT_W'(1));
      length <= len_pad[5:0];
    end
  end

  // Checks
  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    (pc == itoa_pkg::STEP_DIGIT) |-> (div_stat.rem < radix))
    else $error("remainder not below radix");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(WORD_WIDTH))
    else $error("digit count beyond buffer depth");

  a_emit_has_digit: assert property (@(posedge clk) disable iff (rst)
    (pc == itoa_pkg::STEP_EMIT) |-> (count != '0))
    else $error("emit with empty digit buffer");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (go && uw.emit_digit && (count == CNT_W'(1))) |=> (pc == itoa_pkg::STEP_END))
    else $error("last character did not end the conversion");

  a_sign_decimal: assert property (@(posedge clk) disable iff (rst)
    neg |-> (radix == itoa_pkg::SIGN_RADIX))
    else $error("sign flagged outside radix ten");

endmodule
